>>> rtl/core/cnms_pkg.sv
// Package for the Canny non-maximum suppression core.
// Holds field widths, the pixel word type, the class codes and a helper function.
// No dependencies.
package cnms_pkg;

  localparam int MAG_W  = 15;
  localparam int GRAD_W = 16;
  // A signed difference of two magnitudes needs one more bit, for the sign.
  localparam int DIFF_W = MAG_W + 1;
  // The negated x gradient can reach +2^15, so it needs one extra bit.
  localparam int PERP_W = GRAD_W + 1;
  localparam int PROD_W = DIFF_W + PERP_W;
  localparam int SUM_W  = PROD_W + 2;

  // Output class codes.
  typedef enum logic [1:0] {
    CODE_BORDER   = 2'd0,
    CODE_POSSIBLE = 2'd1,
    CODE_NOEDGE   = 2'd2
  } class_code_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic [MAG_W-1:0]         center_mag;
    logic [MAG_W-1:0]         mag_north;
    logic [MAG_W-1:0]         mag_south;
    logic [MAG_W-1:0]         mag_west;
    logic [MAG_W-1:0]         mag_east;
    logic [MAG_W-1:0]         mag_north_west;
    logic [MAG_W-1:0]         mag_north_east;
    logic [MAG_W-1:0]         mag_south_west;
    logic [MAG_W-1:0]         mag_south_east;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     on_border;
  } pixel_t;

  // Signed difference of two unsigned magnitudes.
  function automatic logic signed [DIFF_W-1:0] mag_diff(
    input logic [MAG_W-1:0] a,
    input logic [MAG_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ea;
    logic signed [DIFF_W-1:0] eb;
    ea = $signed({1'b0, a});
    eb = $signed({1'b0, b});
    return ea - eb;
  endfunction

endpackage

>>> rtl/core/cnms_if.sv
// Valid/ready channel interfaces for the non-maximum suppression core.
// Depends on cnms_pkg for widths and the class code type.
interface cnms_pixel_if import cnms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MAG_W-1:0]         center_mag;
  logic [MAG_W-1:0]         mag_north;
  logic [MAG_W-1:0]         mag_south;
  logic [MAG_W-1:0]         mag_west;
  logic [MAG_W-1:0]         mag_east;
  logic [MAG_W-1:0]         mag_north_west;
  logic [MAG_W-1:0]         mag_north_east;
  logic [MAG_W-1:0]         mag_south_west;
  logic [MAG_W-1:0]         mag_south_east;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     on_border;

  modport source (
    output valid, center_mag, mag_north, mag_south, mag_west, mag_east,
           mag_north_west, mag_north_east, mag_south_west, mag_south_east,
           grad_x, grad_y, on_border,
    input  ready
  );
  modport sink (
    input  valid, center_mag, mag_north, mag_south, mag_west, mag_east,
           mag_north_west, mag_north_east, mag_south_west, mag_south_east,
           grad_x, grad_y, on_border,
    output ready
  );
endinterface

interface cnms_result_if import cnms_pkg::*; ();
  logic        valid;
  logic        ready;
  class_code_t class_code;

  modport source (output valid, class_code, input ready);
  modport sink (input valid, class_code, output ready);
endinterface

>>> rtl/core/cnms_classify.sv
// Combinational classifier: octant select, two interpolated differences, decision.
// Depends on cnms_pkg.
module cnms_classify import cnms_pkg::*; (
  input  pixel_t      pix,
  output class_code_t class_code
);

  logic signed [PERP_W-1:0] gx_ext;
  logic signed [PERP_W-1:0] gy_ext;
  logic signed [PERP_W-1:0] perp_x;
  logic signed [PERP_W-1:0] perp_y;
  logic signed [DIFF_W-1:0] a1, b1, a2, b2;
  logic signed [PROD_W-1:0] p1a, p1b, p2a, p2b;
  logic signed [SUM_W-1:0]  d1, d2;
  logic                     d1_pos;
  logic                     d2_nonneg;

  // Gradient terms; the perpendicular x term is the negated x gradient.
  assign gx_ext = PERP_W'(pix.grad_x);
  assign gy_ext = PERP_W'(pix.grad_y);
  assign perp_x = -gx_ext;
  assign perp_y = gy_ext;

  // Octant selection picks the neighbor differences on both sides.
  always_comb begin
    if (!pix.grad_x[GRAD_W-1]) begin
      if (!pix.grad_y[GRAD_W-1]) begin
        if (gx_ext >= gy_ext) begin
          a1 = mag_diff(pix.center_mag, pix.mag_west);
          b1 = mag_diff(pix.mag_north_west, pix.mag_west);
          a2 = mag_diff(pix.center_mag, pix.mag_east);
          b2 = mag_diff(pix.mag_south_east, pix.mag_east);
        end else begin
          a1 = mag_diff(pix.mag_north, pix.mag_north_west);
          b1 = mag_diff(pix.mag_north, pix.center_mag);
          a2 = mag_diff(pix.mag_south, pix.mag_south_east);
          b2 = mag_diff(pix.mag_south, pix.center_mag);
        end
      end else begin
        if (gx_ext >= -gy_ext) begin
          a1 = mag_diff(pix.center_mag, pix.mag_west);
          b1 = mag_diff(pix.mag_west, pix.mag_south_west);
          a2 = mag_diff(pix.center_mag, pix.mag_east);
          b2 = mag_diff(pix.mag_east, pix.mag_north_east);
        end else begin
          a1 = mag_diff(pix.mag_south, pix.mag_south_west);
          b1 = mag_diff(pix.center_mag, pix.mag_south);
          a2 = mag_diff(pix.mag_north, pix.mag_north_east);
          b2 = mag_diff(pix.center_mag, pix.mag_north);
        end
      end
    end else begin
      if (!pix.grad_y[GRAD_W-1]) begin
        if (-gx_ext >= gy_ext) begin
          a1 = mag_diff(pix.mag_east, pix.center_mag);
          b1 = mag_diff(pix.mag_north_east, pix.mag_east);
          a2 = mag_diff(pix.mag_west, pix.center_mag);
          b2 = mag_diff(pix.mag_south_west, pix.mag_west);
        end else begin
          a1 = mag_diff(pix.mag_north_east, pix.mag_north);
          b1 = mag_diff(pix.mag_north, pix.center_mag);
          a2 = mag_diff(pix.mag_south_west, pix.mag_south);
          b2 = mag_diff(pix.mag_south, pix.center_mag);
        end
      end else begin
        if (gy_ext > gx_ext) begin
          a1 = mag_diff(pix.mag_east, pix.center_mag);
          b1 = mag_diff(pix.mag_east, pix.mag_south_east);
          a2 = mag_diff(pix.mag_west, pix.center_mag);
          b2 = mag_diff(pix.mag_west, pix.mag_north_west);
        end else begin
          a1 = mag_diff(pix.mag_south_east, pix.mag_south);
          b1 = mag_diff(pix.center_mag, pix.mag_south);
          a2 = mag_diff(pix.mag_north_west, pix.mag_north);
          b2 = mag_diff(pix.center_mag, pix.mag_north);
        end
      end
    end
  end

  // Exact integer forms of the interpolated differences.
  assign p1a = a1 * perp_x;
  assign p1b = b1 * perp_y;
  assign p2a = a2 * perp_x;
  assign p2b = b2 * perp_y;
  assign d1  = SUM_W'(p1a) + SUM_W'(p1b);
  assign d2  = SUM_W'(p2a) + SUM_W'(p2b);

  assign d1_pos    = !d1[SUM_W-1] && (d1 != '0);
  assign d2_nonneg = !d2[SUM_W-1];

  // Border wins, then a zero center magnitude, then the comparison.
  always_comb begin
    if (pix.on_border) begin
      class_code = CODE_BORDER;
    end else if (pix.center_mag == '0) begin
      class_code = CODE_NOEDGE;
    end else if (d1_pos || d2_nonneg) begin
      class_code = CODE_NOEDGE;
    end else begin
      class_code = CODE_POSSIBLE;
    end
  end

endmodule

>>> rtl/core/canny_non_max_suppression_core.sv
// Canny non-maximum suppression core: one 3x3 magnitude window in, one class code out.
// An accepted word goes through the input register, then the result register.
// Throughput: one word per cycle while the result side is ready; the multiply-add
// of the classifier sits between the input register and the result register.
// Reset (rst, synchronous, active high) clears both valid flags; no other state.
// Depends on cnms_pkg, cnms_if and cnms_classify.
module canny_non_max_suppression_core import cnms_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cnms_pixel_if.sink    pixel,
  cnms_result_if.source result
);

  pixel_t      pix_q;
  logic        pix_valid;
  class_code_t code_next;
  class_code_t code_q;
  logic        out_valid;
  logic        out_load;
  logic        in_load;

  // Ready chain: the result register loads when empty or drained.
  assign out_load    = !out_valid || result.ready;
  assign in_load     = !pix_valid || out_load;
  assign pixel.ready = in_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_load) begin
      pix_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && pixel.valid) begin
      pix_q.center_mag     <= pixel.center_mag;
      pix_q.mag_north      <= pixel.mag_north;
      pix_q.mag_south      <= pixel.mag_south;
      pix_q.mag_west       <= pixel.mag_west;
      pix_q.mag_east       <= pixel.mag_east;
      pix_q.mag_north_west <= pixel.mag_north_west;
      pix_q.mag_north_east <= pixel.mag_north_east;
      pix_q.mag_south_west <= pixel.mag_south_west;
      pix_q.mag_south_east <= pixel.mag_south_east;
      pix_q.grad_x         <= pixel.grad_x;
      pix_q.grad_y         <= pixel.grad_y;
      pix_q.on_border      <= pixel.on_border;
    end
  end

  // Classification logic.
  cnms_classify u_classify (
    .pix        (pix_q),
    .class_code (code_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && pix_valid) begin
      code_q <= code_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.class_code = code_q;

  // A border word moving to the result register comes out as the border code.
  a_border_code: assert property (@(posedge clk) disable iff (rst)
    pix_valid && out_load && pix_q.on_border |=> result.class_code == CODE_BORDER)
    else $error("border word did not give the border code");

  // A non-border word with zero center magnitude is never kept.
  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    pix_valid && out_load && !pix_q.on_border && (pix_q.center_mag == '0)
    |=> result.class_code == CODE_NOEDGE)
    else $error("zero center magnitude was not suppressed");

  // With an empty result register the input side always takes a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> pixel.ready)
    else $error("input stalled while result register was empty");

  // A held word in the input register reaches the output on the next edge when the result register loads.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    pix_valid && out_load |=> result.valid)
    else $error("word in input register was lost");

endmodule

>>> dv/canny_non_max_suppression_core_tb.sv
// Self-checking testbench for canny_non_max_suppression_core.
// Drives pixel windows through the pixel channel and checks each class code word
// against a behavioral predictor. Depends on cnms_pkg, cnms_if and the core RTL.
module canny_non_max_suppression_core_tb;
  import cnms_pkg::*;

  localparam int          RANDOM_PIXELS = 550;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          HOLD_AFTER    = 60;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          REPORT_MAX    = 10;

  // One row of the directed table; typed rows carry their own expected code.
  typedef struct {
    pixel_t      px;
    bit          typed;
    class_code_t code;
  } pixel_row_t;

  logic clk;
  logic rst;

  cnms_pixel_if  pixel();
  cnms_result_if result();

  canny_non_max_suppression_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result)
  );

  class_code_t expected_codes[$];
  pixel_row_t  plan[$];
  int unsigned cycles;
  int          codes_seen;
  int          bad_words;

  // Clock generation and cycle count for the timeout.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Expected class of one window: octant from the gradient signs and sizes,
  // then two interpolated differences weighted by the perpendicular gradient terms.
  function automatic class_code_t predict_class(input pixel_t p);
    longint m, n, s, w, e, nw, ne, sw, se;
    longint gx, gy, px, py, d1, d2;
    m  = p.center_mag;
    n  = p.mag_north;
    s  = p.mag_south;
    w  = p.mag_west;
    e  = p.mag_east;
    nw = p.mag_north_west;
    ne = p.mag_north_east;
    sw = p.mag_south_west;
    se = p.mag_south_east;
    gx = p.grad_x;
    gy = p.grad_y;
    if (p.on_border) begin
      return CODE_BORDER;
    end
    if (m == 0) begin
      return CODE_NOEDGE;
    end
    // The perpendicular terms: the negated x gradient and the y gradient.
    px = -gx;
    py = gy;
    if (gx >= 0) begin
      if (gy >= 0) begin
        if (gx >= gy) begin
          d1 = (m - w) * px + (nw - w) * py;
          d2 = (m - e) * px + (se - e) * py;
        end else begin
          d1 = (n - nw) * px + (n - m) * py;
          d2 = (s - se) * px + (s - m) * py;
        end
      end else begin
        if (gx >= -gy) begin
          d1 = (m - w) * px + (w - sw) * py;
          d2 = (m - e) * px + (e - ne) * py;
        end else begin
          d1 = (s - sw) * px + (m - s) * py;
          d2 = (n - ne) * px + (m - n) * py;
        end
      end
    end else begin
      if (gy >= 0) begin
        if (-gx >= gy) begin
          d1 = (e - m) * px + (ne - e) * py;
          d2 = (w - m) * px + (sw - w) * py;
        end else begin
          d1 = (ne - n) * px + (n - m) * py;
          d2 = (sw - s) * px + (s - m) * py;
        end
      end else begin
        // This octant splits on a strict comparison.
        if (-gx > -gy) begin
          d1 = (e - m) * px + (e - se) * py;
          d2 = (w - m) * px + (w - nw) * py;
        end else begin
          d1 = (se - s) * px + (m - s) * py;
          d2 = (nw - n) * px + (m - n) * py;
        end
      end
    end
    if (d1 > 0 || d2 >= 0) begin
      return CODE_NOEDGE;
    end
    return CODE_POSSIBLE;
  endfunction

  function automatic pixel_t make_pixel(input int c, input int n, input int s, input int w,
                                        input int e, input int nw, input int ne,
                                        input int sw, input int se, input int gx,
                                        input int gy, input bit border);
    pixel_t p;
    p.center_mag     = MAG_W'(c);
    p.mag_north      = MAG_W'(n);
    p.mag_south      = MAG_W'(s);
    p.mag_west       = MAG_W'(w);
    p.mag_east       = MAG_W'(e);
    p.mag_north_west = MAG_W'(nw);
    p.mag_north_east = MAG_W'(ne);
    p.mag_south_west = MAG_W'(sw);
    p.mag_south_east = MAG_W'(se);
    p.grad_x         = GRAD_W'(gx);
    p.grad_y         = GRAD_W'(gy);
    p.on_border      = border;
    return p;
  endfunction

  // Random window: mostly a peaked or near-flat neighborhood so that both
  // possible edges and suppressed pixels show up, plus fully random noise.
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int          mags[9];
    int          ext_grad[5];
    int          ext_mag[2];
    int unsigned shape;
    int unsigned grad_kind;
    int          center;
    int          v;
    ext_grad = '{-32768, -1, 0, 1, 32767};
    ext_mag  = '{0, 32767};
    shape    = $urandom_range(0, 99);
    if (shape < 30) begin
      foreach (mags[i]) mags[i] = $urandom_range(0, 32767);
    end else if (shape < 80) begin
      center = $urandom_range(1, 32767);
      mags[0] = center;
      for (int i = 1; i < 9; i++) begin
        v = center - int'($urandom_range(0, 400));
        if ($urandom_range(0, 3) == 0) v += 600;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        mags[i] = v;
      end
    end else if (shape < 90) begin
      v = $urandom_range(0, 32767);
      foreach (mags[i]) mags[i] = v;
    end else if (shape < 95) begin
      foreach (mags[i]) mags[i] = $urandom_range(0, 32767);
      mags[0] = 0;
    end else begin
      foreach (mags[i]) mags[i] = ext_mag[$urandom_range(0, 1)];
    end
    p = make_pixel(mags[0], mags[1], mags[2], mags[3], mags[4], mags[5], mags[6],
                   mags[7], mags[8], 0, 0, ($urandom_range(0, 9) == 0));
    grad_kind = $urandom_range(0, 9);
    if (grad_kind < 6) begin
      p.grad_x = GRAD_W'($urandom);
      p.grad_y = GRAD_W'($urandom);
    end else if (grad_kind == 6) begin
      // Equal sizes sit on an octant boundary.
      p.grad_x = GRAD_W'($urandom);
      p.grad_y = $urandom_range(0, 1) ? p.grad_x : -p.grad_x;
    end else if (grad_kind == 7) begin
      p.grad_x = GRAD_W'(ext_grad[$urandom_range(0, 4)]);
      p.grad_y = GRAD_W'(ext_grad[$urandom_range(0, 4)]);
    end else begin
      p.grad_x = GRAD_W'(int'($urandom_range(0, 200)) - 100);
      p.grad_y = GRAD_W'(int'($urandom_range(0, 200)) - 100);
    end
    return p;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word and hold it until the core takes it.
  task automatic send_pixel(input pixel_t p, input class_code_t code);
    pixel.valid          <= 1'b1;
    pixel.center_mag     <= p.center_mag;
    pixel.mag_north      <= p.mag_north;
    pixel.mag_south      <= p.mag_south;
    pixel.mag_west       <= p.mag_west;
    pixel.mag_east       <= p.mag_east;
    pixel.mag_north_west <= p.mag_north_west;
    pixel.mag_north_east <= p.mag_north_east;
    pixel.mag_south_west <= p.mag_south_west;
    pixel.mag_south_east <= p.mag_south_east;
    pixel.grad_x         <= p.grad_x;
    pixel.grad_y         <= p.grad_y;
    pixel.on_border      <= p.on_border;
    do @(posedge clk); while (pixel.ready !== 1'b1);
    expected_codes.push_back(code);
  endtask

  task automatic pause_pixels(input int n);
    if (n > 0) begin
      pixel.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what);
    bad_words++;
    if (bad_words <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  // Result check: every accepted word against the oldest expected code.
  always @(posedge clk) begin
    class_code_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      codes_seen++;
      if (expected_codes.size() == 0) begin
        note_mismatch($sformatf("unexpected word, class_code %0d", result.class_code));
      end else begin
        want = expected_codes.pop_front();
        if (result.class_code !== want) begin
          note_mismatch($sformatf("class_code expected %0d actual %0d",
                                  want, result.class_code));
        end
      end
    end
  end

  // Result receiver: random stalls, long ready stretches, and one long hold-off
  // so that the core backs up and stalls the pixel channel.
  initial begin
    bit hold_done;
    int stall;
    int run;
    hold_done = 1'b0;
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && codes_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_idle();
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
    end
  end

  // Timeout.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  // Reset, directed table, random pixels, drain and verdict.
  initial begin
    pixel_t      p;
    class_code_t code;
    cycles     = 0;
    codes_seen = 0;
    bad_words  = 0;
    rst                  <= 1'b1;
    pixel.valid          <= 1'b0;
    pixel.center_mag     <= '0;
    pixel.mag_north      <= '0;
    pixel.mag_south      <= '0;
    pixel.mag_west       <= '0;
    pixel.mag_east       <= '0;
    pixel.mag_north_west <= '0;
    pixel.mag_north_east <= '0;
    pixel.mag_south_west <= '0;
    pixel.mag_south_east <= '0;
    pixel.grad_x         <= '0;
    pixel.grad_y         <= '0;
    pixel.on_border      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Border pixels and zero center magnitude.
    plan.push_back('{make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, -32768, 1'b1), 1'b1, CODE_BORDER});
    plan.push_back('{make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, CODE_BORDER});
    plan.push_back('{make_pixel(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                32767, -32768, 32767, 1'b0), 1'b1, CODE_NOEDGE});
    plan.push_back('{make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, CODE_NOEDGE});
    // Isolated peak, flat plateau and zero gradient.
    plan.push_back('{make_pixel(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 0, 0, 1'b0), 1'b0, CODE_BORDER});
    // One row per octant, a clear peak.
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                300, 100, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                100, 300, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                300, -100, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                100, -300, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                -300, 100, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                -100, 300, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                -300, -100, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(20000, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                -100, -300, 1'b0), 1'b0, CODE_BORDER});
    // Octant boundaries, where gradient sizes are equal.
    plan.push_back('{make_pixel(6500, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                500, 500, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(6500, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                500, -500, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(6500, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000,
                                -500, 500, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(6500, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000,
                                -500, -500, 1'b0), 1'b0, CODE_BORDER});
    // Gradient extremes.
    plan.push_back('{make_pixel(32767, 1, 2, 3, 4, 5, 6, 7, 8, -32768, -32768, 1'b0),
                     1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(32767, 32766, 0, 32766, 0, 32766, 0, 32766, 0,
                                32767, -32768, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(32767, 0, 32766, 0, 32766, 0, 32766, 0, 32766,
                                -32768, 32767, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(32767, 32766, 32766, 32766, 32766, 32766, 32766, 32766,
                                32766, 32767, 32767, 1'b0), 1'b0, CODE_BORDER});
    plan.push_back('{make_pixel(1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1'b0), 1'b0, CODE_BORDER});
    // A larger neighbor on one side suppresses the pixel.
    plan.push_back('{make_pixel(10000, 500, 500, 12000, 500, 500, 500, 500, 500,
                                1000, 0, 1'b0), 1'b0, CODE_BORDER});

    foreach (plan[i]) begin
      code = plan[i].typed ? plan[i].code : predict_class(plan[i].px);
      send_pixel(plan[i].px, code);
      pause_pixels(pick_idle());
    end

    // Random pixels; the first part of every hundred goes with no gaps.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      p = random_pixel();
      send_pixel(p, predict_class(p));
      if (i % 100 >= 20) begin
        pause_pixels(pick_idle());
      end
    end
    pixel.valid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", bad_words);
      $display("status: fail");
    end
    $finish;
  end

endmodule
